// ----- hw/rtl/dcpw_pkg.sv -----
// ----------------------------------------------------------------------------
// dcpw_pkg
// shared types and constants of the direct-color pixel writer
// ----------------------------------------------------------------------------
`default_nettype none

package dcpw_pkg;

  // coordinate clamp bound, default for the top-level parameter
  localparam int unsigned MAX_DIMENSION_DEF = 4096;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_WIDTH  = 3'd0,
    CFG_DISPLAY_HEIGHT = 3'd1,
    CFG_LINE_PITCH     = 3'd2,
    CFG_BYTES_PER_PIX  = 3'd3,
    CFG_RED_LAYOUT     = 3'd4,
    CFG_GREEN_LAYOUT   = 3'd5,
    CFG_BLUE_LAYOUT    = 3'd6
  } cfg_idx_e;

  // register widths
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned PITCH_W  = 15;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned LAYOUT_W = 9;

  // register reset values
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd480;
  localparam logic [PITCH_W-1:0]  PITCH_RST  = 15'd2560;
  localparam logic [BPP_W-1:0]    BPP_RST    = 3'd4;
  localparam logic [LAYOUT_W-1:0] RED_RST    = 9'd272;
  localparam logic [LAYOUT_W-1:0] GREEN_RST  = 9'd264;
  localparam logic [LAYOUT_W-1:0] BLUE_RST   = 9'd256;

  // pixel size codes
  localparam logic [BPP_W-1:0] BPP_1 = 3'd1;
  localparam logic [BPP_W-1:0] BPP_2 = 3'd2;
  localparam logic [BPP_W-1:0] BPP_3 = 3'd3;
  localparam logic [BPP_W-1:0] BPP_4 = 3'd4;

  // byte lane enables per pixel size
  localparam logic [3:0] BE_NONE = 4'h0;
  localparam logic [3:0] BE_1    = 4'h1;
  localparam logic [3:0] BE_2    = 4'h3;
  localparam logic [3:0] BE_3    = 4'h7;
  localparam logic [3:0] BE_4    = 4'hF;

  // color word channel positions and channel width
  localparam int unsigned RED_LSB   = 24;
  localparam int unsigned GREEN_LSB = 16;
  localparam int unsigned BLUE_LSB  = 8;
  localparam int unsigned CHAN_W    = 8;
  localparam logic [3:0]  CHAN_MAX  = 4'd8;

  // payload widths
  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned OFFSET_W   = 26;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned BE_W       = 4;

  typedef struct packed {
    logic [COORD_IN_W-1:0] pixel_x;
    logic [COORD_IN_W-1:0] pixel_y;
    logic [COLOR_W-1:0]    rgb_color;
  } pixel_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [DATA_W-1:0]   write_data;
    logic [BE_W-1:0]     byte_enable;
  } fb_write_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dcpw_pix_if.sv -----
// ----------------------------------------------------------------------------
// dcpw_pix_if
// pixel write channel: valid/ready with one pixel word
// ----------------------------------------------------------------------------
`default_nettype none

interface dcpw_pix_if;
  logic              valid;
  logic              ready;
  dcpw_pkg::pixel_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dcpw_wr_if.sv -----
// ----------------------------------------------------------------------------
// dcpw_wr_if
// framebuffer write channel: valid/ready with offset, data and lane enables
// ----------------------------------------------------------------------------
`default_nettype none

interface dcpw_wr_if;
  logic                 valid;
  logic                 ready;
  dcpw_pkg::fb_write_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/direct_color_pixel_writer.sv -----
// ----------------------------------------------------------------------------
// direct_color_pixel_writer
// turns a pixel write (x, y, rgb color) into one framebuffer write word
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake     word
//   pix_i     in   valid/ready   pixel_x, pixel_y, rgb_color
//   wr_o      out  valid/ready   byte_offset, write_data, byte_enable
//   cfg       in   cfg_we_i      cfg_index_i, cfg_wdata_i (no read-back)
//
// three register stages: clamp and channel right shift, then the two offset
// products and the channel left shifts, then the offset add and lane packing
// into the output register. one word per clock whenever wr_o is not stalled.
// each stage holds its word while the stage after it is full and stalled, so
// a stall on wr_o backs up stage by stage without losing or repeating a word.
// reset clears the stage valid bits and loads the register defaults.
//
`default_nettype none

module direct_color_pixel_writer #(
  parameter int unsigned MAX_DIMENSION = dcpw_pkg::MAX_DIMENSION_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  dcpw_pix_if.sink                            pix_i,
  dcpw_wr_if.source                           wr_o,
  input  wire                                 cfg_we_i,
  input  wire  [dcpw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [dcpw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // clamped coordinate and clamp limit widths
  localparam int unsigned CW = $clog2(MAX_DIMENSION);
  localparam int unsigned LW = $clog2(MAX_DIMENSION + 1);
  // product widths
  localparam int unsigned YP_W = CW + dcpw_pkg::PITCH_W;
  localparam int unsigned XB_W = CW + dcpw_pkg::BPP_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [dcpw_pkg::DIM_W-1:0]    width_q, height_q;
  logic [dcpw_pkg::PITCH_W-1:0]  pitch_q;
  logic [dcpw_pkg::BPP_W-1:0]    bpp_q;
  logic [dcpw_pkg::LAYOUT_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dcpw_pkg::WIDTH_RST;
      height_q <= dcpw_pkg::HEIGHT_RST;
      pitch_q  <= dcpw_pkg::PITCH_RST;
      bpp_q    <= dcpw_pkg::BPP_RST;
      red_q    <= dcpw_pkg::RED_RST;
      green_q  <= dcpw_pkg::GREEN_RST;
      blue_q   <= dcpw_pkg::BLUE_RST;
    end else if (cfg_we_i) begin
      unique case (dcpw_pkg::cfg_idx_e'(cfg_index_i))
        dcpw_pkg::CFG_DISPLAY_WIDTH:  width_q  <= cfg_wdata_i[dcpw_pkg::DIM_W-1:0];
        dcpw_pkg::CFG_DISPLAY_HEIGHT: height_q <= cfg_wdata_i[dcpw_pkg::DIM_W-1:0];
        dcpw_pkg::CFG_LINE_PITCH:     pitch_q  <= cfg_wdata_i[dcpw_pkg::PITCH_W-1:0];
        dcpw_pkg::CFG_BYTES_PER_PIX:  bpp_q    <= cfg_wdata_i[dcpw_pkg::BPP_W-1:0];
        dcpw_pkg::CFG_RED_LAYOUT:     red_q    <= cfg_wdata_i[dcpw_pkg::LAYOUT_W-1:0];
        dcpw_pkg::CFG_GREEN_LAYOUT:   green_q  <= cfg_wdata_i[dcpw_pkg::LAYOUT_W-1:0];
        dcpw_pkg::CFG_BLUE_LAYOUT:    blue_q   <= cfg_wdata_i[dcpw_pkg::LAYOUT_W-1:0];
        default: ; // unmapped index, write ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // effective limit: zero acts as one, anything above the bound is the bound
  function automatic logic [LW-1:0] eff_limit(input logic [dcpw_pkg::DIM_W-1:0] r);
    logic [LW-1:0] lim;
    if (r == '0) begin
      lim = LW'(1);
    end else if (32'(r) > 32'(MAX_DIMENSION)) begin
      lim = LW'(MAX_DIMENSION);
    end else begin
      lim = LW'(r);
    end
    return lim;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(
    input logic [dcpw_pkg::COORD_IN_W-1:0] c,
    input logic [LW-1:0]                   lim
  );
    logic [CW-1:0] res;
    if (32'(c) >= 32'(lim)) begin
      res = CW'(lim - LW'(1));
    end else begin
      res = CW'(c);
    end
    return res;
  endfunction

  // drop the low (8 - size) bits of a channel, size saturates at 8
  function automatic logic [dcpw_pkg::CHAN_W-1:0] chan_rshift(
    input logic [dcpw_pkg::CHAN_W-1:0]   v,
    input logic [dcpw_pkg::LAYOUT_W-1:0] lay
  );
    logic [3:0] sz;
    sz = lay[8:5];
    if (sz > dcpw_pkg::CHAN_MAX) begin
      sz = dcpw_pkg::CHAN_MAX;
    end
    return v >> (dcpw_pkg::CHAN_MAX - sz);
  endfunction

  // --------------------------------------------------------------------------
  // stage handshake: a stage takes a word when it is empty or draining
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy      = !s3_valid_q || wr_o.ready;
  assign s2_rdy      = !s2_valid_q || s3_rdy;
  assign s1_rdy      = !s1_valid_q || s2_rdy;
  assign pix_i.ready = s1_rdy;

  logic s1_load, s2_load, s3_load;
  assign s1_load = s1_rdy && pix_i.valid;
  assign s2_load = s2_rdy && s1_valid_q;
  assign s3_load = s3_rdy && s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_q <= pix_i.valid;
      end
      if (s2_rdy) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_rdy) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: clamp coordinates, cut channels to their size
  // --------------------------------------------------------------------------
  logic [CW-1:0]               s1_x_d, s1_y_d, s1_x_q, s1_y_q;
  logic [dcpw_pkg::CHAN_W-1:0] s1_r_d, s1_g_d, s1_b_d;
  logic [dcpw_pkg::CHAN_W-1:0] s1_r_q, s1_g_q, s1_b_q;

  always_comb begin
    s1_x_d = clamp_coord(pix_i.data.pixel_x, eff_limit(width_q));
    s1_y_d = clamp_coord(pix_i.data.pixel_y, eff_limit(height_q));
    s1_r_d = chan_rshift(pix_i.data.rgb_color[dcpw_pkg::RED_LSB +: dcpw_pkg::CHAN_W], red_q);
    s1_g_d = chan_rshift(pix_i.data.rgb_color[dcpw_pkg::GREEN_LSB +: dcpw_pkg::CHAN_W],
                         green_q);
    s1_b_d = chan_rshift(pix_i.data.rgb_color[dcpw_pkg::BLUE_LSB +: dcpw_pkg::CHAN_W], blue_q);
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_x_q <= s1_x_d;
      s1_y_q <= s1_y_d;
      s1_r_q <= s1_r_d;
      s1_g_q <= s1_g_d;
      s1_b_q <= s1_b_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: line and column products, channels moved to their positions
  // --------------------------------------------------------------------------
  logic [YP_W-1:0]             s2_yp_d, s2_yp_q;
  logic [XB_W-1:0]             s2_xb_d, s2_xb_q;
  logic [dcpw_pkg::DATA_W-1:0] s2_packed_d, s2_packed_q;

  always_comb begin
    s2_yp_d = YP_W'(s1_y_q) * YP_W'(pitch_q);
    s2_xb_d = XB_W'(s1_x_q) * XB_W'(bpp_q);
    // bits moved past bit 31 fall off
    s2_packed_d = (dcpw_pkg::DATA_W'(s1_r_q) << red_q[4:0])
                | (dcpw_pkg::DATA_W'(s1_g_q) << green_q[4:0])
                | (dcpw_pkg::DATA_W'(s1_b_q) << blue_q[4:0]);
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_yp_q     <= s2_yp_d;
      s2_xb_q     <= s2_xb_d;
      s2_packed_q <= s2_packed_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: offset sum and byte lane packing into the output register
  // --------------------------------------------------------------------------
  logic [YP_W:0]       s3_sum;
  dcpw_pkg::fb_write_t s3_d, s3_q;

  always_comb begin
    s3_sum = (YP_W+1)'(s2_yp_q) + (YP_W+1)'(s2_xb_q);
    s3_d.byte_offset = dcpw_pkg::OFFSET_W'(s3_sum);
    unique case (bpp_q)
      dcpw_pkg::BPP_1: begin
        s3_d.write_data  = {24'h0, s2_packed_q[7:0]};
        s3_d.byte_enable = dcpw_pkg::BE_1;
      end
      dcpw_pkg::BPP_2: begin
        s3_d.write_data  = {16'h0, s2_packed_q[15:0]};
        s3_d.byte_enable = dcpw_pkg::BE_2;
      end
      dcpw_pkg::BPP_3: begin
        // three-byte pixels go out high byte first
        s3_d.write_data  = {8'h0, s2_packed_q[7:0], s2_packed_q[15:8], s2_packed_q[23:16]};
        s3_d.byte_enable = dcpw_pkg::BE_3;
      end
      dcpw_pkg::BPP_4: begin
        s3_d.write_data  = s2_packed_q;
        s3_d.byte_enable = dcpw_pkg::BE_4;
      end
      default: begin
        // unsupported pixel size: a write that touches nothing
        s3_d.byte_offset = '0;
        s3_d.write_data  = '0;
        s3_d.byte_enable = dcpw_pkg::BE_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      s3_q <= s3_d;
    end
  end

  assign wr_o.valid = s3_valid_q;
  assign wr_o.data  = s3_q;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the direct-color pixel writer: pixel words go in on
// a valid/ready channel with random gaps, framebuffer words come back under a
// randomly stalled ready, and each one is checked against a predictor of the
// clamp, offset and channel packing, over many register settings
// ----------------------------------------------------------------------------

module tb_top;
  import dcpw_pkg::*;

  // pipeline depth of the block, one word per clock while the sink is ready
  localparam int unsigned PIPE_LATENCY = 3;
  localparam int unsigned MAX_DIM      = MAX_DIMENSION_DEF;
  // chance in a hundred that a side idles in a cycle
  localparam int unsigned IDLE_PCT     = 22;
  // random part: phases times words per phase gives about 850 pixels
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PIX_PER_PH   = 85;
  // the phase that runs with no idling on either side
  localparam int unsigned STEADY_PH    = 3;
  // the phase in which the sink holds off for a long stretch
  localparam int unsigned HOLD_PH      = 6;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 200_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  // configuration write port
  logic                  cfg_we;
  cfg_idx_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dcpw_pix_if pix_if ();
  dcpw_wr_if  wr_if ();

  direct_color_pixel_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_if),
    .wr_o        (wr_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: own copy of the registers, starting at their reset values
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]    cur_width  = WIDTH_RST;
  logic [DIM_W-1:0]    cur_height = HEIGHT_RST;
  logic [PITCH_W-1:0]  cur_pitch  = PITCH_RST;
  logic [BPP_W-1:0]    cur_bpp    = BPP_RST;
  logic [LAYOUT_W-1:0] cur_red    = RED_RST;
  logic [LAYOUT_W-1:0] cur_green  = GREEN_RST;
  logic [LAYOUT_W-1:0] cur_blue   = BLUE_RST;

  // pixels queued by the stimulus, and framebuffer words still owed by the dut
  pixel_t    pixels_waiting[$];
  fb_write_t fb_writes_due[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          no_gaps        = 1'b0;
  bit          hold_go        = 1'b0;
  logic        hold_off       = 1'b0;

  // zero bound counts as one, bounds above the maximum count as the maximum
  function automatic logic [COORD_IN_W-1:0] clamp_coord(logic [COORD_IN_W-1:0] c,
                                                        logic [DIM_W-1:0] lim);
    int unsigned bound;
    bound = lim;
    if (bound == 0) bound = 1;
    if (bound > MAX_DIM) bound = MAX_DIM;
    if (c >= bound) c = COORD_IN_W'(bound - 1);
    return c;
  endfunction

  // layout bits 8:5 are the channel size, 4:0 its position; bits past 31 drop
  function automatic logic [DATA_W-1:0] place_channel(logic [CHAN_W-1:0] chan,
                                                      logic [LAYOUT_W-1:0] layout);
    logic [3:0]  chan_size;
    logic [4:0]  pos;
    logic [39:0] shifted;
    chan_size = layout[8:5];
    pos       = layout[4:0];
    if (chan_size > CHAN_MAX) chan_size = CHAN_MAX;
    shifted = {32'b0, chan >> (CHAN_W - chan_size)};
    shifted = shifted << pos;
    return shifted[DATA_W-1:0];
  endfunction

  function automatic fb_write_t predict_fb_write(pixel_t px);
    fb_write_t             w;
    logic [COORD_IN_W-1:0] col;
    logic [COORD_IN_W-1:0] row;
    logic [DATA_W-1:0]     pix_word;
    logic [31:0]           offset;
    w        = '0;
    col      = clamp_coord(px.pixel_x, cur_width);
    row      = clamp_coord(px.pixel_y, cur_height);
    pix_word = place_channel(px.rgb_color[RED_LSB +: CHAN_W], cur_red)
             | place_channel(px.rgb_color[GREEN_LSB +: CHAN_W], cur_green)
             | place_channel(px.rgb_color[BLUE_LSB +: CHAN_W], cur_blue);
    offset   = row * cur_pitch + col * cur_bpp;
    case (cur_bpp)
      BPP_1: begin
        w.write_data  = {24'b0, pix_word[7:0]};
        w.byte_enable = BE_1;
      end
      BPP_2: begin
        w.write_data  = {16'b0, pix_word[15:0]};
        w.byte_enable = BE_2;
      end
      // 24-bit pixels go out high byte first
      BPP_3: begin
        w.write_data  = {8'b0, pix_word[7:0], pix_word[15:8], pix_word[23:16]};
        w.byte_enable = BE_3;
      end
      BPP_4: begin
        w.write_data  = pix_word;
        w.byte_enable = BE_4;
      end
      // unsupported pixel size: an empty write with no lanes enabled
      default: return '0;
    endcase
    w.byte_offset = offset[OFFSET_W-1:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
             cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // pixel driver: holds a word until it is taken, predicts it on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : pixel_driver
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_if.ready) begin
      // registers only change while nothing is in flight, so the current
      // copy is the one the dut uses for this word
      if (pix_if.valid) fb_writes_due.push_back(predict_fb_write(pix_if.data));
      if (pixels_waiting.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
        pix_if.valid <= 1'b1;
        pix_if.data  <= pixels_waiting.pop_front();
      end else begin
        // junk on the bus while idle, the dut must ignore it
        pix_if.valid <= 1'b0;
        pix_if.data  <= pixel_t'({$urandom, $urandom});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // framebuffer sink: random ready, forced low during the hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : fb_sink
    if (!rst_ni) begin
      wr_if.ready <= 1'b0;
    end else if (hold_off) begin
      wr_if.ready <= 1'b0;
    end else begin
      wr_if.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // long hold-off, counted here so the sender keeps offering meanwhile
  always begin : sink_hold
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
    hold_go = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : fb_monitor
    fb_write_t due;
    if (rst_ni && wr_if.valid && wr_if.ready) begin
      if (fb_writes_due.size() == 0) begin
        report_mismatch("word with none expected, offset", 32'(wr_if.data.byte_offset), 0);
      end else begin
        due = fb_writes_due.pop_front();
        if (wr_if.data.byte_offset !== due.byte_offset)
          report_mismatch("byte_offset", 32'(wr_if.data.byte_offset), 32'(due.byte_offset));
        if (wr_if.data.write_data !== due.write_data)
          report_mismatch("write_data", wr_if.data.write_data, due.write_data);
        if (wr_if.data.byte_enable !== due.byte_enable)
          report_mismatch("byte_enable", 32'(wr_if.data.byte_enable), 32'(due.byte_enable));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register writes, one per clock; the local copy follows each write
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_DISPLAY_WIDTH:  cur_width  = value[DIM_W-1:0];
      CFG_DISPLAY_HEIGHT: cur_height = value[DIM_W-1:0];
      CFG_LINE_PITCH:     cur_pitch  = value[PITCH_W-1:0];
      CFG_BYTES_PER_PIX:  cur_bpp    = value[BPP_W-1:0];
      CFG_RED_LAYOUT:     cur_red    = value[LAYOUT_W-1:0];
      CFG_GREEN_LAYOUT:   cur_green  = value[LAYOUT_W-1:0];
      CFG_BLUE_LAYOUT:    cur_blue   = value[LAYOUT_W-1:0];
      default: ;
    endcase
  endtask

  // random garbage above a register's width, which the dut must drop
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v,
                                                      int unsigned w, bit junk);
    logic [CFG_DATA_W-1:0] keep;
    keep = CFG_DATA_W'((32'd1 << w) - 1);
    return junk ? ((v & keep) | (CFG_DATA_W'($urandom) & ~keep)) : v;
  endfunction

  task automatic set_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                            logic [PITCH_W-1:0] p, logic [BPP_W-1:0] b,
                            logic [LAYOUT_W-1:0] r, logic [LAYOUT_W-1:0] g,
                            logic [LAYOUT_W-1:0] bl, bit junk);
    write_reg(CFG_DISPLAY_WIDTH,  with_junk(w, DIM_W, junk));
    write_reg(CFG_DISPLAY_HEIGHT, with_junk(h, DIM_W, junk));
    write_reg(CFG_LINE_PITCH,     p);
    write_reg(CFG_BYTES_PER_PIX,  with_junk(b, BPP_W, junk));
    write_reg(CFG_RED_LAYOUT,     with_junk(r, LAYOUT_W, junk));
    write_reg(CFG_GREEN_LAYOUT,   with_junk(g, LAYOUT_W, junk));
    write_reg(CFG_BLUE_LAYOUT,    with_junk(bl, LAYOUT_W, junk));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly a channel that fits below bit 32, sometimes any layout at all
  function automatic logic [LAYOUT_W-1:0] random_layout();
    int unsigned chan_size;
    if ($urandom_range(0, 4) == 0) return LAYOUT_W'($urandom);
    chan_size = $urandom_range(0, 8);
    return LAYOUT_W'(chan_size * 32 + $urandom_range(0, 32 - chan_size));
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'(MAX_DIM);
      2:       return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      3:       return DIM_W'(1);
      default: return DIM_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  task automatic random_config();
    logic [PITCH_W-1:0] p;
    logic [BPP_W-1:0]   b;
    case ($urandom_range(0, 5))
      0:       p = PITCH_W'($urandom);
      1:       p = '1;
      2:       p = PITCH_W'(1);
      default: p = PITCH_W'($urandom_range(1, 16384));
    endcase
    // mostly supported sizes, now and then one the dut must reject
    case ($urandom_range(0, 11))
      10:      b = '0;
      11:      b = BPP_W'($urandom_range(5, 7));
      default: b = BPP_W'($urandom_range(1, 4));
    endcase
    set_config(random_dim(), random_dim(), p, b,
               random_layout(), random_layout(), random_layout(), 1'b1);
  endtask

  // coordinates cluster on the clamp boundary and the ends of the field
  function automatic logic [COORD_IN_W-1:0] random_coord(logic [DIM_W-1:0] lim);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return COORD_IN_W'($urandom);
      3:       return clamp_coord('1, lim);
      4:       return clamp_coord('1, lim) + 1'b1;
      default: return COORD_IN_W'($urandom_range(0, lim == 0 ? 0 : lim - 1));
    endcase
  endfunction

  task automatic queue_pixel(logic [COORD_IN_W-1:0] x, logic [COORD_IN_W-1:0] y,
                             logic [COLOR_W-1:0] color);
    pixel_t px;
    px.pixel_x   = x;
    px.pixel_y   = y;
    px.rgb_color = color;
    pixels_waiting.push_back(px);
  endtask

  // wait until every queued pixel has come back as a framebuffer word
  task automatic settle();
    while (pixels_waiting.size() != 0 || pix_if.valid || fb_writes_due.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni       = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    wr_if.ready  = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_DISPLAY_WIDTH;
    cfg_wdata    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset layout, 32-bit pixels: field extremes and the clamp edges
    queue_pixel(16'd0, 16'd0, 32'h0000_0000);
    queue_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_pixel(16'd639, 16'd479, 32'hA5C3_5A3C);
    queue_pixel(16'd640, 16'd480, 32'h5A3C_A5C3);
    queue_pixel(16'h8000, 16'h7FFF, 32'h8001_0080);
    settle();

    // 8-bit pixels, 3-3-2 packing
    set_config(13'd320, 13'd200, 15'd320, BPP_1, 9'd101, 9'd98, 9'd64, 1'b0);
    queue_pixel(16'd319, 16'd199, 32'hFFFF_FF00);
    queue_pixel(16'd17, 16'd3, 32'hE0C0_8011);
    queue_pixel(16'd400, 16'd0, 32'h1F3F_7FFF);
    settle();

    // 16-bit pixels, 5-6-5 packing
    set_config(13'd800, 13'd600, 15'd1600, BPP_2, 9'd171, 9'd197, 9'd160, 1'b0);
    queue_pixel(16'd799, 16'd599, 32'hFFFF_FFFF);
    queue_pixel(16'd1, 16'd1, 32'hF800_F800);
    queue_pixel(16'd65535, 16'd300, 32'h0804_0201);
    settle();

    // 24-bit pixels: lanes go out in reverse byte order
    set_config(13'd1024, 13'd768, 15'd3072, BPP_3, 9'd272, 9'd264, 9'd256, 1'b0);
    queue_pixel(16'd1023, 16'd767, 32'h1122_3344);
    queue_pixel(16'd5, 16'd9, 32'hFF00_FF00);
    queue_pixel(16'd2000, 16'd2000, 32'h00FF_00FF);
    settle();

    // zero width and height pin both coordinates to zero; oversized channel
    // keeps all 8 bits, zero-size channel vanishes
    set_config(13'd0, 13'd0, 15'h7FFF, BPP_4, 9'd511, 9'd7, 9'd288, 1'b0);
    queue_pixel(16'd123, 16'd456, 32'hFFFF_FFFF);
    queue_pixel(16'hFFFF, 16'd0, 32'h8181_8100);
    settle();

    // dimensions above the maximum, offset wraps, bits pushed past bit 31
    set_config(13'd8191, 13'd5000, 15'h7FFF, BPP_4, 9'd284, 9'd276, 9'd268, 1'b0);
    queue_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_pixel(16'd4096, 16'd4095, 32'h8040_2000);
    settle();

    // every unsupported pixel size gives an empty write
    set_config(13'd640, 13'd480, 15'd2560, 3'd0, 9'd272, 9'd264, 9'd256, 1'b0);
    queue_pixel(16'd10, 16'd10, 32'hDEAD_BEEF);
    settle();
    set_config(13'd640, 13'd480, 15'd2560, 3'd5, 9'd272, 9'd264, 9'd256, 1'b0);
    queue_pixel(16'd11, 16'd12, 32'hCAFE_F00D);
    settle();
    set_config(13'd640, 13'd480, 15'd2560, 3'd6, 9'd272, 9'd264, 9'd256, 1'b0);
    queue_pixel(16'd0, 16'd479, 32'h0123_4567);
    settle();
    set_config(13'd640, 13'd480, 15'd2560, 3'd7, 9'd272, 9'd264, 9'd256, 1'b0);
    queue_pixel(16'd639, 16'd0, 32'h89AB_CDEF);
    settle();

    // random part: smallest and largest settings first, then random ones
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       set_config(13'd1, 13'd1, 15'd1, BPP_1, 9'd0, 9'd0, 9'd0, 1'b1);
        1:       set_config(13'd4096, 13'd4096, 15'd16384, BPP_4,
                            9'd287, 9'd287, 9'd287, 1'b1);
        default: random_config();
      endcase
      no_gaps = (ph == STEADY_PH);
      for (int unsigned i = 0; i < PIX_PER_PH; i++)
        queue_pixel(random_coord(cur_width), random_coord(cur_height), $urandom);
      // sink stops while the driver keeps pushing, so the pipeline backs up
      if (ph == HOLD_PH) hold_go = 1'b1;
      settle();
      no_gaps = 1'b0;
    end

    // all words back; give a stray late word the chance to show up
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    if (fb_writes_due.size() != 0)
      report_mismatch("words never delivered", 0, fb_writes_due.size());
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
